// ===== hdl/spq_pkg.sv =====
// Shared types, codes and widths for the stable priority queue.
package spq_pkg;

    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int PRIO_W        = 8;
    localparam int ID_W          = 16;
    localparam int OCC_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } entry_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t entry;
    } cell_ctl_t;

endpackage

// ===== hdl/spq_cmd_if.sv =====
// Command channel: valid/ready handshake with command payload.
interface spq_cmd_if;
    import spq_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PRIO_W-1:0] entry_priority;
    logic [ID_W-1:0]   entry_id;

    modport source (output valid, command, entry_priority, entry_id, input ready);
    modport sink   (input valid, command, entry_priority, entry_id, output ready);
endinterface

// ===== hdl/spq_rsp_if.sv =====
// Result channel: valid/ready handshake with result payload.
interface spq_rsp_if;
    import spq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                out_valid;
    logic [ID_W-1:0]     out_id;
    logic [PRIO_W-1:0]   out_priority;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, status, out_valid, out_id, out_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, out_valid, out_id, out_priority, occupancy,
                    output ready);
endinterface

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts right on insert, left on remove.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  logic               left_ge,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               ge,
    output spq_pkg::entry_t    entry
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Stored entry stays ahead of the new one when its priority is greater or equal.
    assign ge    = occupied && (entry_reg.prio >= ctl.entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert && !ge)
        begin
            // First slot that loses takes the new entry, the rest shift down.
            entry_next = left_ge ? ctl.entry : left_entry;
        end
        else if (ctl.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hdl/stable_priority_queue.sv =====
// Stable priority queue: a chain of slot cells kept sorted highest priority first.
// A command's result is registered at its transfer and offered in the next cycle.
// Throughput: one command per cycle; the input stalls only while a result waits unread.
// The count and the slot chain update together in the same cycle, at the command's transfer.
// Reset clears the entry count and the result valid flag; result payload and slot contents are not reset.
module stable_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_cmd_if.sink   cmd,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]       count_reg, count_next;
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    entry_t              out_entry_reg, out_entry_next;
    logic [OCC_W-1:0]    occ_reg;

    logic      accept;
    logic      full;
    logic      empty;
    cell_ctl_t ctl;
    entry_t    cell_entry [DEPTH];
    logic      cell_ge    [DEPTH];

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        ctl.insert     = 1'b0;
        ctl.remove     = 1'b0;
        ctl.entry.prio = cmd.entry_priority;
        ctl.entry.id   = cmd.entry_id;
        count_next     = count_reg;
        status_next    = ST_DONE;
        out_valid_next = 1'b0;
        out_entry_next = '0;
        case (cmd_t'(cmd.command))
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.insert = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctl.remove     = accept;
                    count_next     = count_reg - CW'(1);
                    out_valid_next = 1'b1;
                    out_entry_next = cell_entry[0];
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic   left_ge;
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_ge    = 1'b1;
            assign left_entry = cell_entry[i];
        end
        else
        begin : g_body
            assign left_ge    = cell_ge[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (CW'(i) < count_reg),
            .left_ge     (left_ge),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .ge          (cell_ge[i]),
            .entry       (cell_entry[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            out_entry_reg <= out_entry_next;
            occ_reg       <= OCC_W'(count_next);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_valid    = out_valid_reg;
    assign rsp.out_id       = out_entry_reg.id;
    assign rsp.out_priority = out_entry_reg.prio;
    assign rsp.occupancy    = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_occ_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> occ_reg == OCC_W'(count_reg))
        else $error("reported occupancy differs from entry count");

    a_removed_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && out_valid_reg) |-> status_reg == ST_DONE)
        else $error("removed entry with non-done status");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.command == CMD_INSERT && full) |=> $stable(count_reg))
        else $error("dropped insert changed the count");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ctl.remove && count_reg > CW'(1))
        |=> out_entry_reg.prio >= cell_entry[0].prio)
        else $error("new head outranks removed entry");

endmodule

// ===== sim/tb_stable_priority_queue.sv =====
// Testbench for the stable priority queue: directed and random commands, results checked in order.
module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam int              QUEUE_DEPTH   = DEPTH_DEFAULT;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam int              STALL_LIMIT   = 4000;
    localparam int              REPORT_LIMIT  = 10;
    localparam int              DRAIN_CYCLES  = 4;

    typedef struct packed {
        status_t           status;
        logic              out_valid;
        logic [ID_W-1:0]   out_id;
        logic [PRIO_W-1:0] out_priority;
        logic [OCC_W-1:0]  occupancy;
    } queue_result_t;

    logic clk;
    logic rst_n;

    spq_cmd_if cmd_bus ();
    spq_rsp_if rsp_bus ();

    stable_priority_queue #(.DEPTH(QUEUE_DEPTH)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    entry_t        sorted_entries[$];
    queue_result_t expected_results[$];
    int            fail_count   = 0;
    int            src_idle_pct = 0;
    int            snk_stall_pct = 0;
    int            quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mirror of the sorted store; returns the result a command should produce.
    function automatic queue_result_t apply_command(input logic [CMD_W-1:0] code,
                                                    input logic [PRIO_W-1:0] prio,
                                                    input logic [ID_W-1:0] id);
        queue_result_t res;
        entry_t        e;
        int            pos;
        res = '0;
        res.status = ST_DONE;
        case (code)
            CMD_INSERT:
            begin
                if (sorted_entries.size() >= QUEUE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    // equal priorities stay in arrival order
                    pos = 0;
                    while (pos < sorted_entries.size() && sorted_entries[pos].prio >= prio)
                        pos++;
                    e.prio = prio;
                    e.id   = id;
                    sorted_entries.insert(pos, e);
                end
            end
            CMD_REMOVE:
            begin
                if (sorted_entries.size() == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    e = sorted_entries.pop_front();
                    res.out_valid    = 1'b1;
                    res.out_id       = e.id;
                    res.out_priority = e.prio;
                end
            end
            CMD_CLEAR:
                sorted_entries.delete();
            default:
                ;
        endcase
        res.occupancy = OCC_W'(sorted_entries.size());
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cmd(input logic [CMD_W-1:0] code,
                            input logic [PRIO_W-1:0] prio,
                            input logic [ID_W-1:0] id);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.command        <= code;
        cmd_bus.entry_priority <= prio;
        cmd_bus.entry_id       <= id;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        expected_results.push_back(apply_command(code, prio, id));
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input queue_result_t want);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("MISMATCH %s: expected st=%0d ov=%0b id=%h pr=%h occ=%0d,",
                     what, want.status, want.out_valid, want.out_id, want.out_priority,
                     want.occupancy,
                     " got st=%0d ov=%0b id=%h pr=%h occ=%0d",
                     rsp_bus.status, rsp_bus.out_valid, rsp_bus.out_id,
                     rsp_bus.out_priority, rsp_bus.occupancy);
    endtask

    always @(negedge clk)
        rsp_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", '0);
            else
            begin
                want = expected_results.pop_front();
                if (rsp_bus.status != want.status)
                    report_mismatch("status", want);
                else if (rsp_bus.out_valid != want.out_valid)
                    report_mismatch("out_valid", want);
                else if (rsp_bus.out_id != want.out_id)
                    report_mismatch("out_id", want);
                else if (rsp_bus.out_priority != want.out_priority)
                    report_mismatch("out_priority", want);
                else if (rsp_bus.occupancy != want.occupancy)
                    report_mismatch("occupancy", want);
            end
        end
    end

    // Any transfer on either channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic test_empty_and_unused;
        send_cmd(CMD_REMOVE, 8'hFF, 16'hFFFF);
        send_cmd(CMD_UNUSED, 8'hFF, 16'hFFFF);
        send_cmd(CMD_CLEAR, 8'h00, 16'h0000);
        send_cmd(CMD_REMOVE, 8'h00, 16'h0000);
    endtask

    task automatic test_ordering;
        send_cmd(CMD_INSERT, 8'h80, 16'h0001);
        send_cmd(CMD_INSERT, 8'h00, 16'h0000);
        send_cmd(CMD_INSERT, 8'hFF, 16'hFFFF);
        send_cmd(CMD_INSERT, 8'h80, 16'h0002);
        send_cmd(CMD_INSERT, 8'h80, 16'h0003);
        send_cmd(CMD_UNUSED, 8'h12, 16'h3456);
        repeat (6)
            send_cmd(CMD_REMOVE, 8'h00, 16'h0000);
    endtask

    task automatic test_full_and_clear;
        repeat (QUEUE_DEPTH)
            send_cmd(CMD_INSERT, 8'($urandom_range(0, 3)), 16'($urandom));
        send_cmd(CMD_INSERT, 8'hFF, 16'hA5A5);
        send_cmd(CMD_REMOVE, 8'h00, 16'h0000);
        send_cmd(CMD_CLEAR, 8'h00, 16'h0000);
        send_cmd(CMD_REMOVE, 8'h00, 16'h0000);
    endtask

    // Alternates fill-biased and drain-biased bursts so the store swings empty to full.
    task automatic test_random_mix(input int count);
        logic [CMD_W-1:0]  code;
        logic [PRIO_W-1:0] prio;
        int                pick;
        int                burst_left;
        bit                filling;
        burst_left = 0;
        filling    = 1'b1;
        repeat (count)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(10, 60);
                filling    = ~filling;
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (pick < 2)
                code = CMD_UNUSED;
            else if (pick < 4)
                code = CMD_CLEAR;
            else if (pick < (filling ? 74 : 36))
                code = CMD_INSERT;
            else
                code = CMD_REMOVE;
            // narrow priorities make ties common
            prio = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
            send_cmd(code, prio, 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.command        = CMD_INSERT;
        cmd_bus.entry_priority = '0;
        cmd_bus.entry_id       = '0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_and_unused();
        test_ordering();
        test_full_and_clear();

        src_idle_pct = 0;  snk_stall_pct = 0;
        test_random_mix(250);
        src_idle_pct = 83; snk_stall_pct = 0;
        test_random_mix(250);
        src_idle_pct = 0;  snk_stall_pct = 83;
        test_random_mix(250);
        src_idle_pct = 10; snk_stall_pct = 10;
        test_random_mix(250);

        cmd_bus.valid <= 1'b0;
        snk_stall_pct = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
